FILE: rtl/rria_pkg.sv
`default_nettype none
package rria_pkg;

  localparam int ID_W = 6;
  localparam int ST_W = 2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [ST_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [ST_W-1:0] STATUS_NONE    = 2'd1;
  localparam logic [ST_W-1:0] STATUS_BAD_REL = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CHK,
    S_SCAN,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/rria_if.sv
`default_nettype none
interface rria_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [rria_pkg::ID_W-1:0] release_id;

  modport source (output valid, output op, output release_id, input ready);
  modport sink   (input valid, input op, input release_id, output ready);
endinterface

interface rria_out_if;
  logic                      valid;
  logic                      ready;
  logic [rria_pkg::ID_W-1:0] granted_id;
  logic [rria_pkg::ST_W-1:0] status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface
`default_nettype wire

FILE: rtl/rria_ram.sv
`default_nettype none
module rria_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/round_robin_id_allocator.sv
// Release and refused allocate: the beat goes through S_CHK to S_RESP, which registers
// the result beat. Allocate: S_CHK, then S_SCAN over up to ID_COUNT-2 map entries
// for the next free id, then S_RESP; the scan reads the map RAM one entry per cycle.
// One item at a time: the next beat is taken the cycle after the result is
// registered, and the result waits while out_bus stalls.
// Reset (rst_n low, synchronous) runs a pass in S_INIT that writes every map entry.
`default_nettype none
module round_robin_id_allocator #(
  parameter int ID_COUNT = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rria_in_if.sink   in_bus,
  rria_out_if.source out_bus
);

  localparam int AW = $clog2(ID_COUNT);
  localparam int CW = ((AW > rria_pkg::ID_W) ? AW : rria_pkg::ID_W) + 1;
  localparam logic [AW-1:0] LAST_ID  = AW'(ID_COUNT - 1);
  localparam logic [AW-1:0] LAST_CNT = AW'(ID_COUNT - 3);

  rria_pkg::state_t state_r, state_nxt;

  logic                          op_r, op_nxt;
  logic [rria_pkg::ID_W-1:0]     rid_r, rid_nxt;
  logic [AW-1:0]                 gid_r, gid_nxt;
  logic [AW-1:0]                 cand_r, cand_nxt;
  logic [AW-1:0]                 cnt_r, cnt_nxt;
  logic [AW-1:0]                 init_r, init_nxt;
  logic [AW-1:0]                 next_free_r, next_free_nxt;
  logic                          none_left_r, none_left_nxt;
  logic [rria_pkg::ID_W-1:0]     res_id_r, res_id_nxt;
  logic [rria_pkg::ST_W-1:0]     res_st_r, res_st_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rria_pkg::ID_W-1:0]     out_id_r;
  logic [rria_pkg::ST_W-1:0]     out_st_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;
  logic          load_out;
  logic          rid_ok;
  logic          in_beat;

  rria_ram #(
    .WIDTH (1),
    .DEPTH (ID_COUNT)
  ) u_free_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [AW-1:0] inc_id(input logic [AW-1:0] x);
    inc_id = (x == LAST_ID) ? AW'(1) : x + AW'(1);
  endfunction

  assign in_bus.ready       = (state_r == rria_pkg::S_IDLE);
  assign in_beat            = in_bus.valid && in_bus.ready;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.granted_id = out_id_r;
  assign out_bus.status     = out_st_r;

  assign rid_ok   = (CW'(rid_r) != '0) && (CW'(rid_r) < CW'(ID_COUNT));
  assign load_out = (state_r == rria_pkg::S_RESP) && (!out_valid_r || out_bus.ready);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    rid_nxt       = rid_r;
    gid_nxt       = gid_r;
    cand_nxt      = cand_r;
    cnt_nxt       = cnt_r;
    init_nxt      = init_r;
    next_free_nxt = next_free_r;
    none_left_nxt = none_left_r;
    res_id_nxt    = res_id_r;
    res_st_nxt    = res_st_r;
    ram_we        = 1'b0;
    ram_waddr     = init_r;
    ram_wdata     = 1'b0;
    ram_raddr     = inc_id(cand_r);

    case (state_r)
      rria_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_r;
        ram_wdata = (init_r != '0);
        init_nxt  = init_r + AW'(1);
        if (init_r == LAST_ID) begin
          state_nxt = rria_pkg::S_IDLE;
        end
      end
      rria_pkg::S_IDLE: begin
        ram_raddr = in_bus.op ? AW'(in_bus.release_id) : next_free_r;
        if (in_beat) begin
          op_nxt    = in_bus.op;
          rid_nxt   = in_bus.release_id;
          gid_nxt   = next_free_r;
          state_nxt = rria_pkg::S_CHK;
        end
      end
      rria_pkg::S_CHK: begin
        ram_raddr = inc_id(gid_r);
        if (op_r == rria_pkg::OP_ALLOC) begin
          if (none_left_r || !ram_rdata) begin
            res_id_nxt = '0;
            res_st_nxt = rria_pkg::STATUS_NONE;
            state_nxt  = rria_pkg::S_RESP;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = gid_r;
            ram_wdata = 1'b0;
            cand_nxt  = inc_id(gid_r);
            cnt_nxt   = '0;
            state_nxt = rria_pkg::S_SCAN;
          end
        end else begin
          res_id_nxt = '0;
          state_nxt  = rria_pkg::S_RESP;
          if (!rid_ok || ram_rdata) begin
            res_st_nxt = rria_pkg::STATUS_BAD_REL;
          end else begin
            res_st_nxt = rria_pkg::STATUS_OK;
            ram_we     = 1'b1;
            ram_waddr  = AW'(rid_r);
            ram_wdata  = 1'b1;
            if (none_left_r) begin
              next_free_nxt = AW'(rid_r);
              none_left_nxt = 1'b0;
            end
          end
        end
      end
      rria_pkg::S_SCAN: begin
        // rdata holds the entry at cand_r; the read for the following one is in flight
        res_id_nxt = rria_pkg::ID_W'(gid_r);
        res_st_nxt = rria_pkg::STATUS_OK;
        if (ram_rdata) begin
          next_free_nxt = cand_r;
          state_nxt     = rria_pkg::S_RESP;
        end else if (cnt_r == LAST_CNT) begin
          none_left_nxt = 1'b1;
          state_nxt     = rria_pkg::S_RESP;
        end else begin
          cand_nxt = inc_id(cand_r);
          cnt_nxt  = cnt_r + AW'(1);
        end
      end
      rria_pkg::S_RESP: begin
        if (load_out) begin
          state_nxt = rria_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rria_pkg::S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rria_pkg::S_INIT;
      init_r      <= '0;
      next_free_r <= AW'(1);
      none_left_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      next_free_r <= next_free_nxt;
      none_left_r <= none_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    rid_r    <= rid_nxt;
    gid_r    <= gid_nxt;
    cand_r   <= cand_nxt;
    cnt_r    <= cnt_nxt;
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    if (load_out) begin
      out_id_r <= res_id_r;
      out_st_r <= res_st_r;
    end
  end

  a_beat_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == rria_pkg::S_CHK))
    else $error("accepted beat did not start a lookup");

  a_scan_not_self: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rria_pkg::S_SCAN) |-> (cand_r != gid_r) && (cand_r != '0))
    else $error("scan candidate is the granted id or zero");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rria_pkg::S_SCAN) |-> !ram_we)
    else $error("free map written during scan");

  a_next_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rria_pkg::S_IDLE) |-> (next_free_r != '0))
    else $error("next pointer is zero");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rria_pkg::S_RESP) && !load_out |=> $stable(res_st_r) && $stable(res_id_r))
    else $error("pending result changed before it was loaded");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none
module tb_top;

  localparam int ID_COUNT    = 64;
  localparam int IW          = $clog2(ID_COUNT);
  localparam int ID_W        = rria_pkg::ID_W;
  localparam int ST_W        = rria_pkg::ST_W;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = ID_COUNT + 8;
  localparam int RANDOM_ITEMS = 400;   // per idling phase, three phases
  localparam int RX_HOLD     = 400;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic [ST_W-1:0] status;
  } grant_t;

  class id_scoreboard;
    bit [ID_COUNT-1:0] free_map;
    bit [ID_W-1:0]     next_id;
    bit                exhausted;
    grant_t            grant_q[$];
    int                errors;

    function new();
      free_map    = '1;
      free_map[0] = 1'b0;
      next_id     = ID_W'(1);
      exhausted   = 1'b0;
      errors      = 0;
    endfunction

    // circular search over 1..ID_COUNT-1 starting after 'from'; 0 means none
    function int find_next_free(int from);
      int cand;
      for (int k = 1; k < ID_COUNT; k++) begin
        cand = ((from - 1 + k) % (ID_COUNT - 1)) + 1;
        if (cand != from && free_map[IW'(cand)]) return cand;
      end
      return 0;
    endfunction

    function void note_input(logic op, logic [ID_W-1:0] rid);
      grant_t g;
      int     nxt;
      g.granted_id = '0;
      g.status     = rria_pkg::STATUS_OK;
      if (op == rria_pkg::OP_ALLOC) begin
        if (exhausted || !free_map[next_id]) begin
          g.status = rria_pkg::STATUS_NONE;
        end else begin
          g.granted_id      = next_id;
          free_map[next_id] = 1'b0;
          nxt = find_next_free(int'(next_id));
          // last free id granted: pointer stays on it
          if (nxt == 0) exhausted = 1'b1;
          else next_id = ID_W'(nxt);
        end
      end else if (rid == '0 || free_map[rid]) begin
        g.status = rria_pkg::STATUS_BAD_REL;
      end else begin
        free_map[rid] = 1'b1;
        if (exhausted) begin
          next_id   = rid;
          exhausted = 1'b0;
        end
      end
      grant_q = {grant_q, g};
    endfunction

    function void check_result(logic [ID_W-1:0] gid, logic [ST_W-1:0] st);
      grant_t exp_g;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result beat: granted_id %0d status %0d", $time, gid, st);
        errors++;
        return;
      end
      exp_g = grant_q.pop_front();
      if (gid !== exp_g.granted_id) begin
        $display("%0t: granted_id expected %0d actual %0d", $time, exp_g.granted_id, gid);
        errors++;
      end
      if (st !== exp_g.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_g.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rria_in_if  in_bus();
  rria_out_if out_bus();

  round_robin_id_allocator #(.ID_COUNT(ID_COUNT)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  id_scoreboard sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_req;
  int sent_items;
  int cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) sb.note_input(in_bus.op, in_bus.release_id);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_result(out_bus.granted_id, out_bus.status);
  end

  // result side: random back-pressure, or a long hold-off when requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != hold_seen) begin
        hold_seen = rx_hold_req;
        hold_left = RX_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(logic op, logic [ID_W-1:0] rid);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.release_id <= rid;
    do @(posedge clk); while (!in_bus.ready);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.grant_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_used_id();
    int cands[$];
    for (int i = 1; i < ID_COUNT; i++)
      if (!sb.free_map[IW'(i)]) cands = {cands, i};
    if (cands.size() == 0) return ID_W'($urandom_range(ID_COUNT - 1));
    return ID_W'(cands[$urandom_range(cands.size() - 1)]);
  endfunction

  // fill until the pool runs dry, then hand back a random share of it
  task automatic run_random(int n_items);
    int  target;
    int  r;
    int  drain_left;
    bit  filling;
    target  = sent_items + n_items;
    filling = 1'b1;
    drain_left = 0;
    while (sent_items < target) begin
      r = $urandom_range(99);
      if (filling) begin
        if (sb.exhausted) begin
          if ($urandom_range(1))
            send_item(rria_pkg::OP_ALLOC, ID_W'($urandom_range(ID_COUNT - 1)));
          filling    = 1'b0;
          drain_left = $urandom_range(1, ID_COUNT - 2);
        end else if (r < 85) begin
          send_item(rria_pkg::OP_ALLOC, ID_W'($urandom_range(ID_COUNT - 1)));
        end else if (r < 95) begin
          send_item(rria_pkg::OP_RELEASE, pick_used_id());
        end else begin
          send_item(rria_pkg::OP_RELEASE, ID_W'($urandom_range(ID_COUNT - 1)));
        end
      end else begin
        if (r < 85) send_item(rria_pkg::OP_RELEASE, pick_used_id());
        else if (r < 92) send_item(rria_pkg::OP_ALLOC, ID_W'($urandom_range(ID_COUNT - 1)));
        else send_item(rria_pkg::OP_RELEASE, ID_W'($urandom_range(ID_COUNT - 1)));
        drain_left--;
        if (drain_left <= 0) filling = 1'b1;
      end
    end
  endtask

  initial begin
    in_bus.valid      <= 1'b0;
    in_bus.op         <= rria_pkg::OP_ALLOC;
    in_bus.release_id <= '0;
    rst_n             <= 1'b0;
    sent_items         = 0;
    rx_hold_req        = 0;
    tx_idle_pct        = 8;
    rx_idle_pct        = 72;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reserved id, free id, ignored release_id on allocate, reuse
    send_item(rria_pkg::OP_RELEASE, 6'd0);
    send_item(rria_pkg::OP_RELEASE, 6'd63);
    send_item(rria_pkg::OP_RELEASE, 6'd5);
    send_item(rria_pkg::OP_ALLOC,   6'd63);
    send_item(rria_pkg::OP_ALLOC,   6'd0);
    send_item(rria_pkg::OP_RELEASE, 6'd1);
    send_item(rria_pkg::OP_RELEASE, 6'd1);
    send_item(rria_pkg::OP_ALLOC,   6'd42);
    send_item(rria_pkg::OP_RELEASE, 6'd2);
    send_item(rria_pkg::OP_RELEASE, 6'd3);
    send_item(rria_pkg::OP_RELEASE, 6'd3);
    send_item(rria_pkg::OP_ALLOC,   6'd21);
    send_item(rria_pkg::OP_RELEASE, 6'd4);
    send_item(rria_pkg::OP_RELEASE, 6'd42);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 8;
          rx_idle_pct = 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct = 8;
          rx_hold_req++;  // sender keeps offering while results back up
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      run_random(RANDOM_ITEMS);
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.grant_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
